### hdl/pdls_pkg.sv
// Shared widths, register codes, reset values and saturation helpers for the PD loop scorer.
package pdls_pkg;

  localparam int POS_W      = 32;
  localparam int SCORE_W    = 40;
  localparam int GAIN_W     = 28;
  localparam int DT_W       = 24;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  localparam int OPND_W     = 33;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SQ_SPLIT   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN    = 2'd0,
    REG_KD_GAIN    = 2'd1,
    REG_STEP_SIZE  = 2'd2,
    REG_RUN_LENGTH = 2'd3
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] KP_GAIN_RST    = 28'd16777216;
  localparam logic [GAIN_W-1:0] KD_GAIN_RST    = 28'd16777216;
  localparam logic [DT_W-1:0]   STEP_SIZE_RST  = 24'd167772;
  localparam logic [RUN_W-1:0]  RUN_LENGTH_RST = 16'd1000;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [DT_W-1:0]   step_size;
    logic [RUN_W-1:0]  run_length;
  } cfg_regs_t;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] wide_t;

  localparam wide_t POS_MAX_W   = 66'sd2147483647;
  localparam wide_t POS_MIN_W   = -66'sd2147483648;
  localparam wide_t SCORE_MAX_W = 66'sd549755813887;
  localparam wide_t SCORE_MIN_W = -66'sd549755813888;

  function automatic logic signed [POS_W-1:0] sat_pos(input wide_t x);
    logic signed [POS_W-1:0] r;
    if (x > POS_MAX_W) begin
      r = signed'(POS_MAX_W[POS_W-1:0]);
    end else if (x < POS_MIN_W) begin
      r = signed'(POS_MIN_W[POS_W-1:0]);
    end else begin
      r = signed'(x[POS_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_score(input wide_t x);
    logic signed [SCORE_W-1:0] r;
    if (x > SCORE_MAX_W) begin
      r = signed'(SCORE_MAX_W[SCORE_W-1:0]);
    end else if (x < SCORE_MIN_W) begin
      r = signed'(SCORE_MIN_W[SCORE_W-1:0]);
    end else begin
      r = signed'(x[SCORE_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic [SCORE_W-1:0] clip_score_max(input wide_t x);
    logic [SCORE_W-1:0] r;
    if (x > SCORE_MAX_W) begin
      r = SCORE_MAX_W[SCORE_W-1:0];
    end else begin
      r = x[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/pdls_ifs.sv
// Valid/ready channel interfaces for tick, result and configuration transfers.
interface pdls_tick_if import pdls_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface pdls_result_if import pdls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position;
  logic signed [SCORE_W-1:0] run_score;
  logic                      last;
  modport source (output valid, output position, output run_score, output last, input ready);
  modport sink (input valid, input position, input run_score, input last, output ready);
endinterface

interface pdls_cfg_if import pdls_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/pdls_cfg.sv
// Configuration register file: gains, step size and run length.
module pdls_cfg import pdls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pdls_cfg_if.sink  cfg,
  output cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp_gain    <= KP_GAIN_RST;
      regs.kd_gain    <= KD_GAIN_RST;
      regs.step_size  <= STEP_SIZE_RST;
      regs.run_length <= RUN_LENGTH_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_KP_GAIN:    regs.kp_gain    <= cfg.data[GAIN_W-1:0];
        REG_KD_GAIN:    regs.kd_gain    <= cfg.data[GAIN_W-1:0];
        REG_STEP_SIZE:  regs.step_size  <= cfg.data[DT_W-1:0];
        REG_RUN_LENGTH: regs.run_length <= cfg.data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/pdls_mul.sv
// Shared signed multiplier with registered product.
module pdls_mul import pdls_pkg::*; (
  input  logic  clk,
  input  opnd_t a,
  input  opnd_t b,
  output wide_t prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### hdl/pd_loop_step_response_scorer_core.sv
// Top level: PD loop Euler step sequencer around one shared multiplier.
//
// Usage:
//   tick   : one transfer advances the simulation by one step; restart = 1
//            starts a fresh run before the step is taken.
//   result : one transfer per tick with the new position, the running score
//            and last, which marks the final step of a run.
//   cfg    : register writes (kp_gain, kd_gain, step_size, run_length),
//            always ready; write only while no tick is in flight.
// Sequencing: after its transfer a tick steps through S_KP to S_DONE; the
// result becomes valid and tick.ready returns in the same cycle, so no new
// tick is taken while one is in progress. The work is eight passes through
// the one 33x33 multiplier, interleaved with dependent add/saturate steps.
// A finished result sits in the output register; a new tick is taken while it
// waits. If the receiver still holds off when the next result is done, the
// sequencer waits in its last step until the output register frees.
// Reset: gains, step size and run length return to their defaults, position,
// velocity, integrals and step count clear, and no result is valid.
module pd_loop_step_response_scorer_core import pdls_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  pdls_tick_if.sink       tick,
  pdls_result_if.source   result,
  pdls_cfg_if.sink        cfg
);

  localparam wide_t ONE_W = wide_t'(1) <<< FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_KP, S_KD, S_ACC, S_ADT, S_VEL, S_VDT, S_POS, S_ERR,
    S_OVR, S_SQ, S_SQS, S_SQH, S_SQL, S_TERM, S_SQACC, S_DONE
  } state_t;

  state_t                    state;
  cfg_regs_t                 regs;
  opnd_t                     mul_a;
  opnd_t                     mul_b;
  wide_t                     prod;

  logic signed [POS_W-1:0]   pos;
  logic signed [POS_W-1:0]   vel;
  logic signed [SCORE_W-1:0] oacc;
  logic signed [SCORE_W-1:0] sqacc;
  logic [RUN_W-1:0]          count;
  logic signed [POS_W-1:0]   err;
  logic signed [POS_W-1:0]   acc;
  wide_t                     sumr;
  wide_t                     hi;
  logic [SCORE_W-1:0]        sq;
  logic [SCORE_W-1:0]        term;

  logic                      out_valid;
  logic signed [POS_W-1:0]   out_position;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_last;

  logic signed [POS_W-1:0]   err_start;
  logic [RUN_W-1:0]          count_next;
  logic                      last_step;
  logic signed [SCORE_W-1:0] score;
  logic                      out_free;

  pdls_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pdls_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign tick.ready       = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.position  = out_position;
  assign result.run_score = out_score;
  assign result.last      = out_last;

  assign err_start  = sat_pos((tick.restart ? wide_t'(0) : wide_t'(pos)) - ONE_W);
  assign count_next = count + RUN_W'(1);
  assign last_step  = (count_next >= regs.run_length);
  assign score      = sat_score((wide_t'(oacc) <<< 3) + (wide_t'(oacc) <<< 1)
                                + wide_t'(sqacc));
  assign out_free   = !out_valid || result.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_KP: begin
        mul_a = opnd_t'(err);
        mul_b = opnd_t'(regs.kp_gain);
      end
      S_KD: begin
        mul_a = opnd_t'(vel);
        mul_b = opnd_t'(regs.kd_gain);
      end
      S_ADT: begin
        mul_a = opnd_t'(acc);
        mul_b = opnd_t'(regs.step_size);
      end
      S_VDT: begin
        mul_a = opnd_t'(vel);
        mul_b = opnd_t'(regs.step_size);
      end
      S_OVR: begin
        mul_a = err[POS_W-1] ? opnd_t'(0) : opnd_t'(err);
        mul_b = opnd_t'(regs.step_size);
      end
      S_SQ: begin
        mul_a = err[POS_W-1] ? -opnd_t'(err) : opnd_t'(err);
        mul_b = err[POS_W-1] ? -opnd_t'(err) : opnd_t'(err);
      end
      S_SQH: begin
        mul_a = opnd_t'(sq[SCORE_W-1:SQ_SPLIT]);
        mul_b = opnd_t'(regs.step_size);
      end
      S_SQL: begin
        mul_a = opnd_t'(sq[SQ_SPLIT-1:0]);
        mul_b = opnd_t'(regs.step_size);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      oacc      <= '0;
      sqacc     <= '0;
      count     <= '0;
    end else begin
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            if (tick.restart) begin
              pos   <= '0;
              vel   <= '0;
              oacc  <= '0;
              sqacc <= '0;
              count <= '0;
            end
            err   <= err_start;
            state <= S_KP;
          end
        end
        S_KP: state <= S_KD;
        S_KD: begin
          sumr  <= -prod;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= sat_pos((sumr - prod) >>> FRAC_BITS);
          state <= S_ADT;
        end
        S_ADT: state <= S_VEL;
        S_VEL: begin
          vel   <= sat_pos(wide_t'(vel) + (prod >>> FRAC_BITS));
          state <= S_VDT;
        end
        S_VDT: state <= S_POS;
        S_POS: begin
          pos   <= sat_pos(wide_t'(pos) + (prod >>> FRAC_BITS));
          state <= S_ERR;
        end
        S_ERR: begin
          err   <= sat_pos(wide_t'(pos) - ONE_W);
          state <= S_OVR;
        end
        S_OVR: state <= S_SQ;
        S_SQ: begin
          oacc  <= sat_score(wide_t'(oacc) - (prod >>> FRAC_BITS));
          state <= S_SQS;
        end
        S_SQS: begin
          sq    <= clip_score_max(prod >>> FRAC_BITS);
          state <= S_SQH;
        end
        S_SQH: state <= S_SQL;
        S_SQL: begin
          hi    <= prod;
          state <= S_TERM;
        end
        S_TERM: begin
          term  <= clip_score_max(((hi <<< SQ_SPLIT) + prod) >>> FRAC_BITS);
          state <= S_SQACC;
        end
        S_SQACC: begin
          sqacc <= sat_score(wide_t'(sqacc) + wide_t'(term));
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_position <= pos;
            out_score    <= score;
            out_last     <= last_step;
            if (last_step) begin
              pos   <= '0;
              vel   <= '0;
              oacc  <= '0;
              sqacc <= '0;
              count <= '0;
            end else begin
              count <= count_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/pdls_chk.sv
// Port-level checker for the PD loop scorer and its bind to the top level.
module pdls_chk import pdls_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      tick_valid,
  input logic                      tick_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic signed [POS_W-1:0]   res_position,
  input logic signed [SCORE_W-1:0] res_run_score,
  input logic                      res_last
);

  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while a step is still in progress");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!tick_ready))
    else $error("result appeared without a step in progress");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !$rose(res_valid))
    else $error("result appeared right after tick transfer");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_position)
      && $stable(res_run_score) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind pd_loop_step_response_scorer_core pdls_chk u_pdls_chk (
  .clk           (clk),
  .rst           (rst),
  .tick_valid    (tick.valid),
  .tick_ready    (tick.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_position  (result.position),
  .res_run_score (result.run_score),
  .res_last      (result.last)
);

### tb/pdls_step_checker.sv
// Checker for the PD loop scorer: tracks config writes, predicts each step and compares results.
module pdls_step_checker import pdls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  pdls_tick_if   tick,
  pdls_result_if result,
  pdls_cfg_if    cfg,
  output int     fail_count,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FB        = 24;
  localparam longint UNIT      = longint'(1) << FB;
  localparam longint MAX_SCORE = (longint'(1) << (SCORE_W - 1)) - 1;

  typedef longint unsigned u64_t;

  typedef struct {
    logic signed [POS_W-1:0]   position;
    logic signed [SCORE_W-1:0] run_score;
    logic                      last;
  } step_out_t;

  longint           kp, kd, dt;
  logic [RUN_W-1:0] run_len;
  longint           pos, vel, over_int, sq_int;
  logic [RUN_W-1:0] steps;
  step_out_t        expected_steps[$];
  int               n_fail;

  assign fail_count = n_fail;

  function automatic longint clip(longint x, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic void clear_run();
    pos      = 0;
    vel      = 0;
    over_int = 0;
    sq_int   = 0;
    steps    = '0;
  endfunction

  function automatic step_out_t advance_sim(logic restart);
    longint    err, accel, over, mag, score;
    u64_t      sq, term;
    step_out_t o;
    if (restart) clear_run();
    err   = clip(pos - UNIT, POS_W);
    accel = clip((-(kp * err) - kd * vel) >>> FB, POS_W);
    vel   = clip(vel + ((accel * dt) >>> FB), POS_W);
    pos   = clip(pos + ((vel * dt) >>> FB), POS_W);
    err   = clip(pos - UNIT, POS_W);
    over  = (err > 0) ? err : 0;
    over_int = clip(over_int - ((over * dt) >>> FB), SCORE_W);
    mag  = (err < 0) ? -err : err;
    sq   = (u64_t'(mag) * u64_t'(mag)) >> FB;
    if (sq > u64_t'(MAX_SCORE)) sq = u64_t'(MAX_SCORE);
    term = (sq * u64_t'(dt)) >> FB;
    if (term > u64_t'(MAX_SCORE)) term = u64_t'(MAX_SCORE);
    sq_int = clip(sq_int + longint'(term), SCORE_W);
    score  = clip(10 * over_int + sq_int, SCORE_W);
    steps  = steps + 1'b1;
    o.position  = pos[POS_W-1:0];
    o.run_score = score[SCORE_W-1:0];
    o.last      = (steps >= run_len);
    if (o.last) clear_run();
    return o;
  endfunction

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("[%0t] step check failed: %s", $time, msg);
  endfunction

  initial n_fail = 0;

  always @(posedge clk) begin
    step_out_t got, want;
    if (rst) begin
      kp      = longint'(KP_GAIN_RST);
      kd      = longint'(KD_GAIN_RST);
      dt      = longint'(STEP_SIZE_RST);
      run_len = RUN_LENGTH_RST;
      clear_run();
      expected_steps.delete();
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_KP_GAIN:    kp      = longint'(cfg.data[GAIN_W-1:0]);
          REG_KD_GAIN:    kd      = longint'(cfg.data[GAIN_W-1:0]);
          REG_STEP_SIZE:  dt      = longint'(cfg.data[DT_W-1:0]);
          REG_RUN_LENGTH: run_len = cfg.data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready)
        expected_steps.insert(expected_steps.size(), advance_sim(tick.restart));
      if (result.valid && result.ready) begin
        got.position  = result.position;
        got.run_score = result.run_score;
        got.last      = result.last;
        if (expected_steps.size() == 0) begin
          note_fail($sformatf("unexpected result position=%0d score=%0d last=%0b",
                              got.position, got.run_score, got.last));
        end else begin
          want = expected_steps.pop_front();
          if (got.position !== want.position)
            note_fail($sformatf("position exp %0d got %0d", want.position, got.position));
          if (got.run_score !== want.run_score)
            note_fail($sformatf("run_score exp %0d got %0d", want.run_score, got.run_score));
          if (got.last !== want.last)
            note_fail($sformatf("last exp %0b got %0b", want.last, got.last));
        end
      end
      outstanding <= expected_steps.size();
    end
  end

endmodule

### tb/tb_pd_loop_step_response_scorer_core.sv
// Testbench top for the PD loop scorer: clock, reset, stimulus, receiver stalls and verdict.
module tb_pd_loop_step_response_scorer_core;
  import pdls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  bit   calm;
  bit   hold_req;
  int   stall_left;

  pdls_tick_if   tick_ch();
  pdls_result_if result_ch();
  pdls_cfg_if    cfg_ch();

  pd_loop_step_response_scorer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  pdls_step_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_ch),
    .result      (result_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {CFG_DATA_W{1'b1}};
      2, 3:    return CFG_DATA_W'($urandom_range(0, 32'h0400_0000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    logic [3:0] hi;
    hi = 4'($urandom);
    case ($urandom_range(0, 5))
      0:       return {hi, 24'd0};
      1:       return {hi, 24'hFF_FFFF};
      2:       return {hi, 24'($urandom_range(1, 24'hFF_FFFF))};
      default: return {hi, 24'($urandom_range(1, 32'h0020_0000))};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_run_length();
    logic [11:0] hi;
    hi = 12'($urandom);
    case ($urandom_range(0, 7))
      0:       return {hi, 16'd0};
      1:       return {hi, 16'd1};
      2:       return {hi, 16'hFFFF};
      3:       return {hi, 16'd1000};
      default: return {hi, 16'($urandom_range(2, 30))};
    endcase
  endfunction

  task automatic wait_drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] kd,
                              logic [CFG_DATA_W-1:0] dt, logic [CFG_DATA_W-1:0] rl);
    wait_drain();
    cfg_write(REG_KP_GAIN, kp);
    cfg_write(REG_KD_GAIN, kd);
    cfg_write(REG_STEP_SIZE, dt);
    cfg_write(REG_RUN_LENGTH, rl);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_tick(logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= restart;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic run_ticks(int n, int restart_pct);
    for (int i = 0; i < n; i++) send_tick($urandom_range(0, 99) < restart_pct);
    tick_ch.valid <= 1'b0;
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  initial begin
    calm     = 1'b0;
    hold_req = 1'b0;
    rst             <= 1'b1;
    tick_ch.valid   <= 1'b0;
    tick_ch.restart <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_KP_GAIN;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    tick_ch.valid <= 1'b0;

    apply_config({CFG_DATA_W{1'b1}}, '0, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
    run_ticks(8, 0);
    apply_config(28'h200_0000, {CFG_DATA_W{1'b1}}, 28'h40_0000, '0);
    run_ticks(3, 0);
    apply_config(KP_GAIN_RST, KD_GAIN_RST, '0, 28'd2);
    run_ticks(3, 0);
    apply_config(28'h400_0000, 28'h80_0000, 28'h20_0000, 28'd100);
    run_ticks(3, 0);
    apply_config(28'h400_0000, 28'h80_0000, 28'h20_0000, 28'd2);
    run_ticks(1, 0);

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        apply_config({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
                     {CFG_DATA_W{1'b1}});
      end else begin
        apply_config(pick_gain(), pick_gain(), pick_step(), pick_run_length());
      end
      calm = (p == 2 || p == 5);
      if (p == 4) hold_req = 1'b1;
      run_ticks(48, 5);
    end

    calm = 1'b0;
    wait_drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
